// ===== src/isl_pkg.sv =====
`default_nettype none

package isl_pkg;

    // wide enough for any position 0..256
    localparam int LIST_POS_W = 9;

    typedef enum logic [2:0] {
        KIND_APPEND      = 3'd0,
        KIND_REMOVE_LAST = 3'd1,
        KIND_INSERT      = 3'd2,
        KIND_ERASE       = 3'd3,
        KIND_READ_AT     = 3'd4,
        KIND_READ_FIRST  = 3'd5,
        KIND_READ_LAST   = 3'd6,
        KIND_CLEAR       = 3'd7
    } isl_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } isl_status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2
    } isl_cell_op_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         index;
        logic signed [31:0] value;
    } isl_cmd_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
        logic [4:0]         count_after;
    } isl_rsp_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        isl_cell_op_t           op;
        logic [LIST_POS_W-1:0]  pos;
        logic signed [31:0]     value;
    } isl_bcast_t;

endpackage

`default_nettype wire

// ===== src/isl_cell.sv =====
`default_nettype none

module isl_cell #(
    parameter int POS = 0
) (
    input  wire                        clk,
    input  isl_pkg::isl_bcast_t        bc,
    input  wire logic signed [31:0]    prev_data,
    input  wire logic signed [31:0]    next_data,
    output logic signed [31:0]         data
);
    import isl_pkg::*;

    localparam logic [LIST_POS_W-1:0] POS_C = LIST_POS_W'(POS);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (bc.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                // the cell at the insert point loads the new value; cells above it take the lower neighbor
                if (POS_C == bc.pos)
                begin
                    data_next = bc.value;
                end
                else if (POS_C > bc.pos)
                begin
                    data_next = prev_data;
                end
            end
            CELL_ERASE:
            begin
                if (POS_C >= bc.pos)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== src/indexed_shift_list.sv =====
`default_nettype none

// channel   dir   handshake                payload
// cmd       in    cmd_valid / cmd_ready    isl_cmd_t {kind, index, value}
// rsp       out   rsp_valid / rsp_ready    isl_rsp_t {read_data, status, count_after}
//
// one command per cycle while rsp is drained: every cell shifts or loads in parallel in the cycle
// the command is taken, and the result sits in an output register in the next cycle
// cmd_ready stays high while the output register is empty or being drained
// reset clears the fill count and the output valid; cell contents are left as is
// a stalled rsp holds its result and blocks only the next command

module indexed_shift_list #(
    parameter int CAPACITY = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  isl_pkg::isl_cmd_t   cmd,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output isl_pkg::isl_rsp_t   rsp
);
    import isl_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [LIST_POS_W-1:0] CAP_C = LIST_POS_W'(CAPACITY);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    isl_rsp_t           rsp_reg;
    isl_rsp_t           rsp_next;

    logic               cmd_fire;
    logic [LIST_POS_W-1:0] idx_w;
    logic [LIST_POS_W-1:0] cnt_w;
    logic [LIST_POS_W-1:0] rd_pos;
    logic               rd_ok;
    logic               is_full;
    logic               is_empty;
    isl_status_t        st;
    isl_bcast_t         bc;

    logic signed [31:0] cell_data [CAPACITY];

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign idx_w    = LIST_POS_W'(cmd.index);
    assign cnt_w    = LIST_POS_W'(count_reg);
    assign is_full  = (cnt_w == CAP_C);
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        st         = ST_OK;
        count_next = count_reg;
        rd_ok      = 1'b0;
        rd_pos     = '0;
        bc.op      = CELL_HOLD;
        bc.pos     = idx_w;
        bc.value   = cmd.value;
        unique case (isl_kind_t'(cmd.kind))
            KIND_APPEND:
            begin
                if (is_full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    bc.op      = CELL_INSERT;
                    bc.pos     = cnt_w;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE_LAST:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_INSERT:
            begin
                // range is checked before fullness
                if (idx_w > cnt_w)
                begin
                    st = ST_RANGE;
                end
                else if (is_full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    bc.op      = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_ERASE:
            begin
                if (idx_w >= cnt_w)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    bc.op      = CELL_ERASE;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ_AT:
            begin
                if (idx_w >= cnt_w)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    rd_ok  = 1'b1;
                    rd_pos = idx_w;
                end
            end
            KIND_READ_FIRST:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
            KIND_READ_LAST:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_ok  = 1'b1;
                    rd_pos = cnt_w - 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                count_next = '0;
            end
        endcase
        if (!cmd_fire)
        begin
            bc.op      = CELL_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        rsp_next.read_data   = rd_ok ? cell_data[rd_pos[ADDR_W-1:0]] : 32'sd0;
        rsp_next.status      = st;
        rsp_next.count_after = 5'(count_next);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] prev_d;
            logic signed [31:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = cell_data[gi];
            end
            else
            begin : g_mid_lo
                assign prev_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_d = cell_data[gi];
            end
            else
            begin : g_mid_hi
                assign next_d = cell_data[gi+1];
            end
            isl_cell #(
                .POS(gi)
            ) u_cell (
                .clk       (clk),
                .bc        (bc),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LIST_POS_W'(count_reg) <= CAP_C)
        else $error("fill count above capacity");

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> rsp_valid)
        else $error("accepted item produced no result");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count_after == 5'(count_reg)))
        else $error("reported count differs from fill count");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.read_data == 32'sd0))
        else $error("failed command returned nonzero data");

endmodule

`default_nettype wire
